FILE: rtl/archive_directory_lookup_macros.svh
// Assertion macros for the archive directory lookup block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ARCHIVE_DIRECTORY_LOOKUP_MACROS_SVH
`define ARCHIVE_DIRECTORY_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ADL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ADL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/adl_pkg.sv
// Shared types and codes for the archive directory lookup block.
// No dependencies.
package adl_pkg;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_BYTE  = 3'd1,
        CMD_FIND  = 3'd2,
        CMD_NAME  = 3'd3,
        CMD_INDEX = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_MISS      = 3'd1,
        ST_NOT_READY = 3'd2,
        ST_BAD_COUNT = 3'd3,
        ST_LOADED    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DIR    = 2'd1,
        PH_DONE   = 2'd2,
        PH_BAD    = 2'd3
    } phase_t;

    localparam logic [3:0]  HDR_LAST_POS = 4'd5;
    localparam logic [3:0]  ENTRY_LAST_POS = 4'd11;
    localparam logic [19:0] DIR_BASE = 20'd6;

endpackage

FILE: rtl/adl_byte_cell.sv
// One byte cell of a shift chain; hands its byte to the next cell on enable.
// Depends on nothing.
module adl_byte_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       clr,
    input  logic [7:0] din,
    output logic [7:0] dout
);
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (clr)
        begin
            byte_next = 8'd0;
        end
        else if (en)
        begin
            byte_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;
endmodule

FILE: rtl/adl_dir_mem.sv
// Directory store: id, offset and size words, one write port per word, one
// shared read address with registered read data. Depends on nothing.
module adl_dir_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we_id,
    input  logic          we_off,
    input  logic          we_size,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rd_id,
    output logic [31:0]   rd_off,
    output logic [31:0]   rd_size
);
    logic [31:0] ids_mem   [DEPTH];
    logic [31:0] offs_mem  [DEPTH];
    logic [31:0] sizes_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we_id)
        begin
            ids_mem[waddr] <= wdata;
        end
        if (we_off)
        begin
            offs_mem[waddr] <= wdata;
        end
        if (we_size)
        begin
            sizes_mem[waddr] <= wdata;
        end
        rd_id   <= ids_mem[raddr];
        rd_off  <= offs_mem[raddr];
        rd_size <= sizes_mem[raddr];
    end
endmodule

FILE: rtl/archive_directory_lookup.sv
// Archive directory lookup top level: header parse, directory load, lookups.
// Depends on adl_pkg, adl_byte_cell, adl_dir_mem and the macros header.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  input   | in_valid / in_stall | command archive_byte query_id name_char
//          |                     | name_last entry_index
//  output  | out_valid/out_stall | status entry_id entry_offset entry_size
//          |                     | entry_total
//
// Archive bytes, start and name characters are accepted whenever the input is not stalled.
// Find by id or name scans the store entry by entry, from the first, through
// S_SCAN_RD and S_SCAN_CMP and the single registered read port.
// Index fetch reads the entry through S_IDX and the same read port.
// Reset clears all control state; the store itself holds no reset value.
// Input is stalled while a lookup runs or a result waits to be taken.
`include "archive_directory_lookup_macros.svh"

module archive_directory_lookup
    import adl_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  archive_byte,
    input  logic [31:0] query_id,
    input  logic [7:0]  name_char,
    input  logic        name_last,
    input  logic [11:0] entry_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] entry_id,
    output logic [32:0] entry_offset,
    output logic [31:0] entry_size,
    output logic [15:0] entry_total
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [16:0] MAX_L = 17'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_IDX
    } state_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [3:0]  bpos_reg, bpos_next;
    logic [15:0] fill_reg, fill_next;
    logic [19:0] dir_end_reg, dir_end_next;
    logic [31:0] hash_reg, hash_next;
    logic [1:0]  slot_reg, slot_next;
    logic [15:0] scan_reg, scan_next;
    logic [31:0] qid_reg, qid_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] id_reg, id_next;
    logic [32:0] off_reg, off_next;
    logic [31:0] size_reg, size_next;
    logic [15:0] total_reg, total_next;

    logic        accept;
    logic        gather_en, gather_clr, name_en, name_clr;
    logic [7:0]  gcell [4];
    logic [7:0]  ncell [4];
    logic [7:0]  uc_char;
    logic [31:0] gather_new, word_new, partial, hash_wrap, h_final;
    logic [1:0]  slot_new;
    logic        slot_wrap;
    logic        we_id, we_off, we_size;
    logic [AW-1:0] raddr;
    logic [31:0] rd_id, rd_off, rd_size;
    logic [15:0] idx16;
    logic [15:0] scan_inc, fill_inc;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;

    // Byte gather chain: new bytes enter at the top cell and move down.
    assign gather_en  = accept && (command == CMD_BYTE) && (phase_reg == PH_DIR);
    assign gather_clr = accept && (command == CMD_START);
    assign gather_new = {archive_byte, gcell[3], gcell[2], gcell[1]};

    // Name chain: uppercase, then shift in the same way.
    assign uc_char   = (name_char >= 8'h61 && name_char <= 8'h7A) ? name_char - 8'h20
                                                                 : name_char;
    assign word_new  = {uc_char, ncell[3], ncell[2], ncell[1]};
    assign slot_new  = slot_reg + 2'd1;
    assign slot_wrap = (slot_new == 2'd0);
    assign name_en   = accept && (command == CMD_NAME);
    assign name_clr  = name_en && (slot_wrap || name_last);
    assign hash_wrap = {hash_reg[30:0], hash_reg[31]} + word_new;

    always_comb
    begin
        case (slot_new)
            2'd1:    partial = word_new >> 24;
            2'd2:    partial = word_new >> 16;
            2'd3:    partial = word_new >> 8;
            default: partial = word_new;
        endcase
    end

    assign h_final = slot_wrap ? hash_wrap : ({hash_reg[30:0], hash_reg[31]} + partial);

    genvar gi;
    generate
        for (gi = 0; gi < 4; gi++)
        begin : g_cells
            logic [7:0] gdin, ndin;
            if (gi == 3)
            begin : g_top
                assign gdin = archive_byte;
                assign ndin = uc_char;
            end
            else
            begin : g_mid
                assign gdin = gcell[gi+1];
                assign ndin = ncell[gi+1];
            end
            adl_byte_cell u_gather (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (gather_en),
                .clr  (gather_clr),
                .din  (gdin),
                .dout (gcell[gi])
            );
            adl_byte_cell u_name (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (name_en),
                .clr  (name_clr),
                .din  (ndin),
                .dout (ncell[gi])
            );
        end
    endgenerate

    // Store each completed word of the current entry.
    assign we_id   = gather_en && (bpos_reg == 4'd3);
    assign we_off  = gather_en && (bpos_reg == 4'd7);
    assign we_size = gather_en && (bpos_reg == ENTRY_LAST_POS);

    assign idx16 = {4'd0, entry_index};
    assign raddr = (state_reg == S_IDLE) ? idx16[AW-1:0] : scan_reg[AW-1:0];

    adl_dir_mem #(
        .DEPTH(MAX_ENTRIES),
        .AW   (AW)
    ) u_mem (
        .clk    (clk),
        .we_id  (we_id),
        .we_off (we_off),
        .we_size(we_size),
        .waddr  (fill_reg[AW-1:0]),
        .wdata  (gather_new),
        .raddr  (raddr),
        .rd_id  (rd_id),
        .rd_off (rd_off),
        .rd_size(rd_size)
    );

    assign scan_inc = scan_reg + 16'd1;
    assign fill_inc = fill_reg + 16'd1;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        bpos_next      = bpos_reg;
        fill_next      = fill_reg;
        dir_end_next   = dir_end_reg;
        hash_next      = hash_reg;
        slot_next      = slot_reg;
        scan_next      = scan_reg;
        qid_next       = qid_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        id_next        = id_reg;
        off_next       = off_reg;
        size_next      = size_reg;
        total_next     = total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Default result: empty data, current count.
                    id_next    = 32'd0;
                    off_next   = 33'd0;
                    size_next  = 32'd0;
                    total_next = count_reg;
                    case (command)
                        CMD_START:
                        begin
                            phase_next = PH_HEADER;
                            bpos_next  = 4'd0;
                            fill_next  = 16'd0;
                        end
                        CMD_BYTE:
                        begin
                            if (phase_reg == PH_HEADER)
                            begin
                                if (bpos_reg == 4'd0)
                                begin
                                    count_next = {8'd0, archive_byte};
                                end
                                else if (bpos_reg == 4'd1)
                                begin
                                    count_next = {archive_byte, count_reg[7:0]};
                                end
                                bpos_next = bpos_reg + 4'd1;
                                if (bpos_reg == HDR_LAST_POS)
                                begin
                                    bpos_next = 4'd0;
                                    fill_next = 16'd0;
                                    if (count_reg == 16'd0 || {1'b0, count_reg} > MAX_L)
                                    begin
                                        phase_next     = PH_BAD;
                                        out_valid_next = 1'b1;
                                        status_next    = ST_BAD_COUNT;
                                    end
                                    else
                                    begin
                                        phase_next   = PH_DIR;
                                        dir_end_next = DIR_BASE + {1'b0, count_reg, 3'd0}
                                                     + {2'd0, count_reg, 2'd0};
                                    end
                                end
                            end
                            else if (phase_reg == PH_DIR)
                            begin
                                bpos_next = bpos_reg + 4'd1;
                                if (bpos_reg == ENTRY_LAST_POS)
                                begin
                                    bpos_next = 4'd0;
                                    fill_next = fill_inc;
                                    if (fill_inc >= count_reg)
                                    begin
                                        phase_next     = PH_DONE;
                                        out_valid_next = 1'b1;
                                        status_next    = ST_LOADED;
                                    end
                                end
                            end
                        end
                        CMD_FIND:
                        begin
                            qid_next = query_id;
                            if (phase_reg != PH_DONE)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_NOT_READY;
                            end
                            else
                            begin
                                scan_next  = 16'd0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        CMD_NAME:
                        begin
                            slot_next = slot_new;
                            if (slot_wrap)
                            begin
                                hash_next = hash_wrap;
                            end
                            if (name_last)
                            begin
                                hash_next = 32'd0;
                                slot_next = 2'd0;
                                qid_next  = h_final;
                                if (phase_reg != PH_DONE)
                                begin
                                    out_valid_next = 1'b1;
                                    status_next    = ST_NOT_READY;
                                end
                                else
                                begin
                                    scan_next  = 16'd0;
                                    state_next = S_SCAN_RD;
                                end
                            end
                        end
                        CMD_INDEX:
                        begin
                            if (phase_reg != PH_DONE)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_NOT_READY;
                            end
                            else if (idx16 >= count_reg || {1'b0, idx16} >= MAX_L)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_MISS;
                            end
                            else
                            begin
                                state_next = S_IDX;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && out_stall;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (rd_id == qid_reg)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_FOUND;
                    id_next        = rd_id;
                    off_next       = {1'b0, rd_off} + {13'd0, dir_end_reg};
                    size_next      = rd_size;
                end
                else if (scan_inc >= count_reg)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_MISS;
                end
                else
                begin
                    scan_next  = scan_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_IDX:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                status_next    = ST_FOUND;
                id_next        = rd_id;
                off_next       = {1'b0, rd_off} + {13'd0, dir_end_reg};
                size_next      = rd_size;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HEADER;
            count_reg     <= 16'd0;
            bpos_reg      <= 4'd0;
            fill_reg      <= 16'd0;
            dir_end_reg   <= DIR_BASE;
            hash_reg      <= 32'd0;
            slot_reg      <= 2'd0;
            scan_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            bpos_reg      <= bpos_next;
            fill_reg      <= fill_next;
            dir_end_reg   <= dir_end_next;
            hash_reg      <= hash_next;
            slot_reg      <= slot_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold while stalled, no reset needed.
    always_ff @(posedge clk)
    begin
        qid_reg    <= qid_next;
        status_reg <= status_next;
        id_reg     <= id_next;
        off_reg    <= off_next;
        size_reg   <= size_next;
        total_reg  <= total_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_id     = id_reg;
    assign entry_offset = off_reg;
    assign entry_size   = size_reg;
    assign entry_total  = total_reg;

    `ADL_ASSERT_NOW(a_scan_in_range, state_reg == S_SCAN_CMP, scan_reg < count_reg,
        "scan index beyond loaded count")
    `ADL_ASSERT_NOW(a_lookup_needs_load, state_reg != S_IDLE, phase_reg == PH_DONE,
        "lookup running without a loaded directory")
    `ADL_ASSERT_NEXT(a_loaded_fill, accept && command == CMD_BYTE && phase_reg == PH_DIR
        && bpos_reg == ENTRY_LAST_POS && fill_inc >= count_reg,
        out_valid_reg && status_reg == ST_LOADED && fill_reg == count_reg,
        "load completion lost or fill count wrong")
endmodule

FILE: bench/tb_top.sv
// Self-checking bench for archive_directory_lookup: loads directories, runs lookups.
// Depends on adl_pkg and the archive_directory_lookup RTL.
`timescale 1ns / 100ps

module tb_top;
    import adl_pkg::*;

    localparam int DIR_CAP = 4096;

    typedef struct {
        logic [2:0]  st;
        logic [31:0] id;
        logic [32:0] off;
        logic [31:0] sz;
        logic [15:0] tot;
    } lookup_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [7:0]  archive_byte;
    logic [31:0] query_id;
    logic [7:0]  name_char;
    logic        name_last;
    logic [11:0] entry_index;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] entry_id;
    logic [32:0] entry_offset;
    logic [31:0] entry_size;
    logic [15:0] entry_total;

    archive_directory_lookup DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .archive_byte(archive_byte), .query_id(query_id),
        .name_char(name_char), .name_last(name_last), .entry_index(entry_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .entry_id(entry_id), .entry_offset(entry_offset),
        .entry_size(entry_size), .entry_total(entry_total)
    );

    // Mirror of the block's directory and parse state.
    logic [31:0] dir_id_tab   [DIR_CAP];
    logic [31:0] dir_off_tab  [DIR_CAP];
    logic [31:0] dir_size_tab [DIR_CAP];
    logic [15:0] hdr_count;
    phase_t      phase;
    int          pos;
    int          filled;
    logic [31:0] gather;
    logic [31:0] hash_acc;
    logic [31:0] word_acc;
    logic [1:0]  slot_acc;

    lookup_result_t pending_results[$];

    // Stimulus knobs and bookkeeping.
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_request;
    int    hold_left;
    int    mismatches;
    int    results_seen;
    int    items_sent;
    string name_bank[$];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // Fold one name character into a running hash, exactly as the block does.
    function automatic void name_step(input logic [7:0] ch, inout logic [31:0] h,
                                      inout logic [31:0] w, inout logic [1:0] s);
        logic [7:0] c;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A)
            c = c - 8'h20;
        w = {c, w[31:8]};
        s = s + 2'd1;
        if (s == 2'd0)
        begin
            h = {h[30:0], h[31]} + w;
            w = '0;
        end
    endfunction

    // Close a name: fold any partial word, zero-padded from the top.
    function automatic logic [31:0] name_close(input logic [31:0] h, input logic [31:0] w,
                                               input logic [1:0] s);
        if (s != 2'd0)
            return {h[30:0], h[31]} + (w >> (8 * (4 - s)));
        return h;
    endfunction

    function automatic logic [31:0] name_hash_of(input string nm);
        logic [31:0] h;
        logic [31:0] w;
        logic [1:0]  s;
        h = '0;
        w = '0;
        s = '0;
        for (int i = 0; i < nm.len(); i++)
            name_step(nm[i], h, w, s);
        return name_close(h, w, s);
    endfunction

    function automatic lookup_result_t make_result(input status_t st);
        lookup_result_t r;
        r.st  = st;
        r.id  = '0;
        r.off = '0;
        r.sz  = '0;
        r.tot = hdr_count;
        return r;
    endfunction

    function automatic lookup_result_t entry_hit(input int k);
        lookup_result_t r;
        r     = make_result(ST_FOUND);
        r.id  = dir_id_tab[k];
        r.off = {1'b0, dir_off_tab[k]} + 33'd6 + 33'd12 * hdr_count;
        r.sz  = dir_size_tab[k];
        return r;
    endfunction

    // First matching entry wins.
    function automatic lookup_result_t scan_for_id(input logic [31:0] id);
        for (int k = 0; k < hdr_count && k < DIR_CAP; k++)
            if (dir_id_tab[k] == id)
                return entry_hit(k);
        return make_result(ST_MISS);
    endfunction

    // Advance the mirror by one accepted transfer; report the result it causes.
    function automatic void predict_transfer(input logic [2:0] cmd, input logic [7:0] b,
            input logic [31:0] qid, input logic [7:0] ch, input logic last,
            input logic [11:0] idx, output bit has, output lookup_result_t r);
        logic [31:0] h;
        has = 1'b0;
        r   = make_result(ST_MISS);
        case (cmd)
            CMD_START:
            begin
                phase  = PH_HEADER;
                pos    = 0;
                filled = 0;
                gather = '0;
            end
            CMD_BYTE:
                if (phase == PH_HEADER)
                begin
                    if (pos == 0)
                        hdr_count = {8'h00, b};
                    else if (pos == 1)
                        hdr_count[15:8] = b;
                    pos++;
                    if (pos == 6)
                    begin
                        pos    = 0;
                        filled = 0;
                        gather = '0;
                        if (hdr_count == 0 || hdr_count > DIR_CAP)
                        begin
                            phase = PH_BAD;
                            has   = 1'b1;
                            r     = make_result(ST_BAD_COUNT);
                        end
                        else
                            phase = PH_DIR;
                    end
                end
                else if (phase == PH_DIR)
                begin
                    gather = {b, gather[31:8]};
                    pos++;
                    if (pos == 4)
                        dir_id_tab[filled] = gather;
                    else if (pos == 8)
                        dir_off_tab[filled] = gather;
                    else if (pos == 12)
                    begin
                        dir_size_tab[filled] = gather;
                        pos    = 0;
                        gather = '0;
                        filled++;
                        if (filled >= hdr_count)
                        begin
                            phase = PH_DONE;
                            has   = 1'b1;
                            r     = make_result(ST_LOADED);
                        end
                    end
                end
            CMD_FIND:
            begin
                has = 1'b1;
                r   = (phase != PH_DONE) ? make_result(ST_NOT_READY) : scan_for_id(qid);
            end
            CMD_NAME:
            begin
                name_step(ch, hash_acc, word_acc, slot_acc);
                if (last)
                begin
                    h        = name_close(hash_acc, word_acc, slot_acc);
                    hash_acc = '0;
                    word_acc = '0;
                    slot_acc = '0;
                    has      = 1'b1;
                    r = (phase != PH_DONE) ? make_result(ST_NOT_READY) : scan_for_id(h);
                end
            end
            CMD_INDEX:
            begin
                has = 1'b1;
                if (phase != PH_DONE)
                    r = make_result(ST_NOT_READY);
                else if (idx >= hdr_count)
                    r = make_result(ST_MISS);
                else
                    r = entry_hit(idx);
            end
            default: ;
        endcase
    endfunction

    // Receiver: random stall, long hold-offs on request, and the result check.
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (out_valid && !out_stall && rst_n)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d id %h", status, entry_id);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || entry_id !== want.id || entry_offset !== want.off
                    || entry_size !== want.sz || entry_total !== want.tot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp st %0d id %h off %h sz %h tot %0d",
                                 want.st, want.id, want.off, want.sz, want.tot);
                        $display("          got st %0d id %h off %h sz %h tot %0d",
                                 status, entry_id, entry_offset, entry_size, entry_total);
                    end
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one transfer, hold it until accepted, then predict and maybe go idle.
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] b,
                             input logic [31:0] qid, input logic [7:0] ch,
                             input logic last, input logic [11:0] idx);
        bit             has;
        lookup_result_t r;
        command      <= cmd;
        archive_byte <= b;
        query_id     <= qid;
        name_char    <= ch;
        name_last    <= last;
        entry_index  <= idx;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_transfer(cmd, b, qid, ch, last, idx, has, r);
        if (has)
            pending_results.push_back(r);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Shorthands that fill unused fields with noise.
    task automatic send_cmd(input logic [2:0] cmd);
        send_item(cmd, $urandom, $urandom, $urandom_range(1, 255), $urandom, $urandom);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b, $urandom, $urandom_range(1, 255), $urandom, $urandom);
    endtask

    task automatic send_find(input logic [31:0] id);
        send_item(CMD_FIND, $urandom, id, $urandom_range(1, 255), $urandom, $urandom);
    endtask

    task automatic send_index(input logic [11:0] idx);
        send_item(CMD_INDEX, $urandom, $urandom, $urandom_range(1, 255), $urandom, idx);
    endtask

    task automatic send_name(input string nm);
        for (int i = 0; i < nm.len(); i++)
            send_item(CMD_NAME, $urandom, $urandom, nm[i], (i == nm.len() - 1),
                      $urandom);
    endtask

    task automatic send_header(input logic [15:0] cnt);
        send_cmd(CMD_START);
        send_byte(cnt[7:0]);
        send_byte(cnt[15:8]);
        repeat (4)
            send_byte($urandom);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_byte(w[8*i +: 8]);
    endtask

    function automatic string random_name();
        string nm;
        int    len;
        len = $urandom_range(1, 9);
        nm  = "";
        for (int i = 0; i < len; i++)
        begin
            // favor letters, lower case included, to exercise the case fold
            case ($urandom_range(3))
                0:       nm = {nm, string'(8'($urandom_range(8'h61, 8'h7A)))};
                1:       nm = {nm, string'(8'($urandom_range(8'h41, 8'h5A)))};
                default: nm = {nm, string'(8'($urandom_range(1, 255)))};
            endcase
        end
        return nm;
    endfunction

    // Load a directory of n entries; some ids are name hashes, some repeat.
    task automatic load_directory(input int n);
        logic [31:0] id;
        string       nm;
        name_bank.delete();
        send_header(n[15:0]);
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    nm = random_name();
                    name_bank.push_back(nm);
                    id = name_hash_of(nm);
                end
                4:       id = (k > 0) ? dir_id_tab[$urandom_range(k - 1)] : $urandom;
                default: id = $urandom;
            endcase
            send_word(id);
            send_word($urandom);
            send_word($urandom);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    // Lookups before any directory is loaded, and ignored commands.
    task automatic test_not_ready();
        send_find(32'hFFFF_FFFF);
        send_index(12'hFFF);
        send_name("ab");
        send_cmd(3'd5);
        send_cmd(3'd6);
        send_cmd(3'd7);
        send_byte(8'h00);
        wait_drained();
    endtask

    // Counts of zero and above capacity; bytes after a bad count are dropped.
    task automatic test_bad_count();
        send_header(16'd0);
        send_byte(8'hFF);
        send_find(32'h0);
        send_header(16'd4097);
        send_header(16'hFFFF);
        send_index(12'd0);
        wait_drained();
    endtask

    // Extreme entry values, restart mid-load, bytes after load, all lookup kinds.
    task automatic test_directed_directory();
        send_header(16'd3);
        send_word(32'h1234_5678);
        send_byte(8'hAA);
        send_find(32'h1234_5678);
        load_directory(2);
        dir_id_tab[0] = dir_id_tab[0];
        send_byte(8'h55);
        send_find(dir_id_tab[1]);
        send_index(12'd1);
        send_index(12'd2);
        send_index(12'hFFF);
        send_header(16'd1);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_find(32'hFFFF_FFFF);
        send_find(32'h0000_0000);
        send_name("z");
        send_name("aBcDe");
        wait_drained();
    endtask

    // A directory followed by a random mix of lookups and noise.
    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n);
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_directory($urandom_range(1, 2));
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_find(($urandom_range(1) != 0) ? dir_id_tab[$urandom_range(hdr_count - 1)]
                                                    : $urandom);
            else if (pick < 55)
                send_name((name_bank.size() > 0 && $urandom_range(1) != 0)
                          ? name_bank[$urandom_range(name_bank.size() - 1)] : random_name());
            else if (pick < 80)
                send_index(($urandom_range(1) != 0) ? $urandom_range(hdr_count - 1)
                                                     : $urandom);
            else if (pick < 88)
                send_byte($urandom);
            else if (pick < 94)
                send_cmd($urandom_range(5, 7));
            else
            begin
                // broken load: truncated header, lookup, then a fresh directory
                send_cmd(CMD_START);
                repeat ($urandom_range(0, 5))
                    send_byte($urandom);
                send_index($urandom);
                load_directory($urandom_range(1, 2));
            end
        end
        wait_drained();
    endtask

    // Hold the receiver off while lookups pile up, then pause until all arrive.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_directory(3);
        hold_request = 300;
        for (int i = 0; i < 12; i++)
            send_index($urandom_range(4));
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        send_find(dir_id_tab[2]);
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        command        = CMD_START;
        archive_byte   = '0;
        query_id       = '0;
        name_char      = 8'd1;
        name_last      = 1'b0;
        entry_index    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        mismatches     = 0;
        results_seen   = 0;
        items_sent     = 0;
        hdr_count      = '0;
        phase          = PH_HEADER;
        pos            = 0;
        filled         = 0;
        gather         = '0;
        hash_acc       = '0;
        word_acc       = '0;
        slot_acc       = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_not_ready();
        test_bad_count();
        test_directed_directory();
        run_random_phase(0, 0, 6);
        run_random_phase(55, 0, 6);
        run_random_phase(0, 55, 6);
        run_random_phase(25, 25, 6);
        test_backpressure();

        $display("covered: not-ready, bad counts, restarts, find/name/index lookups");
        $display("transfers in: %0d, results checked: %0d, mismatches: %0d",
                 items_sent, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
